### sv/udf_pkg.sv
package udf_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] WRITE_FLAG  = 8'h80;
	localparam logic [7:0] CRC_POLY    = 8'h8C;
	localparam logic [1:0] NODE_RESET  = 2'd0;
	localparam logic [7:0] SYNC_RESET  = 8'd5;

	localparam int unsigned FRAME_BYTES = 7;
	localparam int unsigned FRAME_W     = FRAME_BYTES * 8;

	// index of the CRC byte within a datagram
	localparam logic [2:0] LAST_IDX_WRITE = 3'd7;
	localparam logic [2:0] LAST_IDX_READ  = 3'd3;

	typedef enum logic {
		CFG_NODE_ADDRESS = 1'b0,
		CFG_SYNC_PATTERN = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic        func;
		logic [6:0]  reg_address;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
	} res_t;

	typedef struct packed {
		logic               is_write;
		logic [FRAME_W-1:0] frame;
	} q_entry_t;

	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### sv/udf_front.sv
module udf_front import udf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       request,
	input  logic       cfg_we,
	input  cfg_index_t cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       q_full,
	output logic       q_push,
	output q_entry_t   q_wdata
);

	logic [1:0] node_q;
	logic [7:0] sync_q;
	logic       valid_s1;
	q_entry_t   entry_s1;
	logic       accept;
	logic [7:0] reg_byte;

	assign busy   = valid_s1 && q_full;
	assign accept = start && !busy;
	assign q_push = valid_s1 && !q_full;
	assign q_wdata = entry_s1;

	// write requests flag the register byte
	assign reg_byte = request.func ? (WRITE_FLAG | {1'b0, request.reg_address})
	                               : {1'b0, request.reg_address};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= NODE_RESET;
			sync_q <= SYNC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NODE_ADDRESS: node_q <= cfg_data[1:0];
				CFG_SYNC_PATTERN: sync_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1.is_write <= request.func;
			entry_s1.frame    <= {sync_q, {6'b0, node_q}, reg_byte, request.write_data};
		end
	end

endmodule

### sv/udf_queue.sv
module udf_queue import udf_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  q_entry_t                   wdata,
	input  logic                       pop,
	output q_entry_t                   rdata,
	output logic                       full,
	output logic                       not_empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	q_entry_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign count     = count_q;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

### sv/udf_back.sv
module udf_back import udf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_not_empty,
	input  q_entry_t q_rdata,
	output logic     q_pop,
	output logic     strobe,
	output res_t     result
);

	logic               active_q;
	logic [2:0]         cnt_q;
	logic [2:0]         last_idx_q;
	logic [FRAME_W-1:0] shreg_q;
	logic [7:0]         crc_q;
	logic               strobe_q;
	res_t               result_q;
	logic               at_last;
	logic [7:0]         head_byte;

	assign head_byte = shreg_q[FRAME_W-1 -: 8];
	assign at_last   = (cnt_q == last_idx_q);
	assign q_pop     = q_not_empty && (!active_q || at_last);
	assign strobe    = strobe_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (q_pop) begin
				active_q <= 1'b1;
			end else if (at_last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active_q) begin
			result_q.tx_byte   <= at_last ? crc_q : head_byte;
			result_q.last_byte <= at_last;
		end
		if (q_pop) begin
			// load the next datagram straight behind the CRC byte
			shreg_q    <= q_rdata.frame;
			last_idx_q <= q_rdata.is_write ? LAST_IDX_WRITE : LAST_IDX_READ;
			cnt_q      <= '0;
			crc_q      <= '0;
		end else if (active_q) begin
			shreg_q <= shreg_q << 8;
			cnt_q   <= cnt_q + 1'b1;
			crc_q   <= crc_byte(crc_q, head_byte);
		end
	end

endmodule

### sv/uart_register_datagram_framer.sv
// Register-access datagram framer. Raise start with a request while busy is low;
// a write sends 8 bytes (sync, node, register with bit 7 set, data MSB first, CRC-8)
// and a read sends 4 (sync, node, register, CRC-8), one word per cycle on result
// with strobe high, last_byte marking the CRC. The byte serializer emits one word
// per clock, and datagrams follow each other without gaps while the queue holds the
// next; words pass the input register, queue, serializer and output register.
// Requests wait in a small queue behind an input register; busy rises only when
// both are full. The receiver cannot stall: every strobed word must be taken.
// node_address and sync_pattern are sampled when a request is accepted.
module uart_register_datagram_framer import udf_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       request,
	output logic       strobe,
	output res_t       result,
	input  logic       cfg_we,
	input  cfg_index_t cfg_index,
	input  logic [7:0] cfg_data
);

	logic                       q_full;
	logic                       q_push;
	logic                       q_pop;
	logic                       q_not_empty;
	logic [$clog2(DEPTH+1)-1:0] q_count;
	q_entry_t                   q_wdata;
	q_entry_t                   q_rdata;

	udf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	udf_queue #(
		.DEPTH (DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wdata),
		.pop       (q_pop),
		.rdata     (q_rdata),
		.full      (q_full),
		.not_empty (q_not_empty),
		.count     (q_count)
	);

	udf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_rdata     (q_rdata),
		.q_pop       (q_pop),
		.strobe      (strobe),
		.result      (result)
	);

	a_busy_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (q_count == ($clog2(DEPTH+1))'(DEPTH)))
		else $error("busy raised with room in the queue");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_not_empty)
		else $error("pop from an empty queue");

	a_last_on_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last_byte) |=> !(strobe && result.last_byte))
		else $error("two consecutive last words");

endmodule

### sim/datagram_checker.sv
`timescale 1ns / 100ps

module datagram_checker import udf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  req_t       request,
	input  logic       strobe,
	input  res_t       result,
	input  logic       cfg_we,
	input  cfg_index_t cfg_index,
	input  logic [7:0] cfg_data,
	output int         errors,
	output int         pending,
	output int         words
);

	logic [1:0] node;
	logic [7:0] sync;
	res_t       expected_bytes[$];
	int         fails;
	int         checked;

	// bit-serial reflected CRC-8: feed data LSB first
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		logic       fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ data[i];
			c  = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	task automatic predict_datagram(input req_t r);
		logic [7:0] bytes[8];
		logic [7:0] crc;
		int         n;
		bytes[0] = sync;
		bytes[1] = {6'b0, node};
		if (r.func) begin
			bytes[2] = WRITE_FLAG | {1'b0, r.reg_address};
			{bytes[3], bytes[4], bytes[5], bytes[6]} = r.write_data;
			n = 7;
		end else begin
			// read: data is dropped, no payload bytes
			bytes[2] = {1'b0, r.reg_address};
			n = 3;
		end
		crc = 8'h00;
		for (int k = 0; k < n; k++) begin
			crc = crc8_update(crc, bytes[k]);
		end
		bytes[n] = crc;
		for (int k = 0; k <= n; k++) begin
			expected_bytes.push_back(res_t'{tx_byte: bytes[k], last_byte: (k == n)});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			expected_bytes.delete();
			node    = NODE_RESET;
			sync    = SYNC_RESET;
			fails   = 0;
			checked = 0;
			errors  <= 0;
			pending <= 0;
			words   <= 0;
		end else begin
			if (strobe) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected word: tx_byte %h last_byte %b",
						result.tx_byte, result.last_byte);
					fails++;
				end else begin
					want = expected_bytes.pop_front();
					checked++;
					if (result.tx_byte !== want.tx_byte) begin
						$error("tx_byte: expected %h, got %h", want.tx_byte, result.tx_byte);
						fails++;
					end
					if (result.last_byte !== want.last_byte) begin
						$error("last_byte: expected %b, got %b",
							want.last_byte, result.last_byte);
						fails++;
					end
				end
			end
			// config is latched with the request, so predict before applying a write
			if (start && !busy) begin
				predict_datagram(request);
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_NODE_ADDRESS: node = cfg_data[1:0];
					CFG_SYNC_PATTERN: sync = cfg_data;
					default: ;
				endcase
			end
			pending <= expected_bytes.size();
			errors  <= fails;
			words   <= checked;
		end
	end

endmodule

### sim/uart_register_datagram_framer_tb.sv
`timescale 1ns / 100ps

module uart_register_datagram_framer_tb;
	import udf_pkg::*;

	localparam int   WATCHDOG_LIMIT = 2000;
	localparam logic FUNC_READ      = 1'b0;
	localparam logic FUNC_WRITE     = 1'b1;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	req_t       request = '0;
	logic       strobe;
	res_t       result;
	logic       cfg_we = 1'b0;
	cfg_index_t cfg_index = CFG_NODE_ADDRESS;
	logic [7:0] cfg_data = 8'h00;

	int errors;
	int pending;
	int words;
	int reads = 0;
	int writes = 0;
	int settings = 1;
	int stall_cycles = 0;

	always #5 clk = ~clk;

	uart_register_datagram_framer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.strobe    (strobe),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	datagram_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.strobe    (strobe),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.words     (words)
	);

	// bail out if neither a request nor a word moves for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// hold start high until the request is taken
	task automatic send(input logic func, input logic [6:0] addr, input logic [31:0] data);
		start   <= 1'b1;
		request <= req_t'{func: func, reg_address: addr, write_data: data};
		do @(posedge clk); while (busy);
		if (func == FUNC_WRITE) begin
			writes++;
		end else begin
			reads++;
		end
	endtask

	task automatic maybe_idle();
		if ($urandom_range(99) < 22) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// drop start and wait for every expected word, plus the pipeline latency
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	// node gets random upper bits to show they are masked off
	task automatic set_config(input logic [1:0] node, input logic [7:0] sync);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_NODE_ADDRESS;
		cfg_data  <= {6'($urandom), node};
		@(posedge clk);
		cfg_index <= CFG_SYNC_PATTERN;
		cfg_data  <= sync;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic run_random(input int count, input bit idling);
		repeat (count) begin
			if (idling) begin
				maybe_idle();
			end
			send(1'($urandom_range(1)), 7'($urandom), $urandom);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config, field extremes, read with data that must be ignored
		send(FUNC_READ, 7'd0, 32'h0000_0000);
		send(FUNC_READ, 7'd127, 32'hFFFF_FFFF);
		send(FUNC_WRITE, 7'd0, 32'h0000_0000);
		send(FUNC_WRITE, 7'd127, 32'hFFFF_FFFF);
		send(FUNC_WRITE, 7'h55, 32'h8000_0001);
		send(FUNC_READ, 7'h2A, 32'h1234_5678);
		run_random(20, 1'b1);
		drain();

		set_config(2'd3, 8'hFF);
		send(FUNC_WRITE, 7'd127, 32'hFFFF_FFFF);
		send(FUNC_READ, 7'd127, 32'h0000_0000);
		send(FUNC_WRITE, 7'd0, 32'h0000_00FF);
		run_random(45, 1'b1);
		drain();

		// back-to-back requests, no idling
		set_config(2'd0, 8'h00);
		send(FUNC_READ, 7'd0, 32'h0000_0000);
		send(FUNC_WRITE, 7'd0, 32'h0000_0000);
		run_random(50, 1'b0);
		drain();

		set_config(2'd1, 8'hA5);
		run_random(50, 1'b1);
		drain();

		set_config(2'd2, 8'($urandom));
		run_random(50, 1'b1);
		drain();

		set_config(2'($urandom), 8'($urandom));
		run_random(45, 1'b1);
		drain();

		$display("Covered %0d reads and %0d writes under %0d node/sync settings,",
			reads, writes, settings);
		$display("%0d datagram bytes compared, %0d mismatches.", words, errors);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

### uart_register_datagram_framer.f
sv/udf_pkg.sv
sv/udf_front.sv
sv/udf_queue.sv
sv/udf_back.sv
sv/uart_register_datagram_framer.sv
sim/datagram_checker.sv
sim/uart_register_datagram_framer_tb.sv
